@@ rtl/core/jdtm_pkg.sv @@
// shared types and constants for the jtag debug transport module
`timescale 1ns / 1ps
`default_nettype none

package jdtm_pkg;

  // instruction register width and codes
  localparam int IR_BITS = 5;
  localparam logic [IR_BITS-1:0] INS_IDCODE = 5'h01;
  localparam logic [IR_BITS-1:0] INS_DTMCS  = 5'h10;
  localparam logic [IR_BITS-1:0] INS_DMI    = 5'h11;
  localparam logic [IR_BITS-1:0] INS_BYPASS = 5'h1f;

  // debug bus register: op 1..0, data 33..2, address above
  localparam int ADDRESS_BITS_DEF = 7;
  localparam int BUS_FIXED_BITS   = 34;
  localparam int DATA_BITS        = 32;
  localparam logic [1:0] OP_READ  = 2'b01;
  localparam logic [1:0] OP_WRITE = 2'b10;

  // status word bit that forces a tap reset
  localparam int HARD_RESET_BIT = 16;

  // configuration
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDCODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE   = 2'd1;
  localparam logic [31:0] IDCODE_RESET = 32'hdeadbeef;
  localparam logic [2:0]  IDLE_RESET   = 3'd4;

  // tap controller states
  typedef enum logic [15:0] {
    TAP_TLR   = 16'h0001,
    TAP_RTI   = 16'h0002,
    TAP_SELDR = 16'h0004,
    TAP_CAPDR = 16'h0008,
    TAP_SHDR  = 16'h0010,
    TAP_EX1DR = 16'h0020,
    TAP_PAUDR = 16'h0040,
    TAP_EX2DR = 16'h0080,
    TAP_UPDR  = 16'h0100,
    TAP_SELIR = 16'h0200,
    TAP_CAPIR = 16'h0400,
    TAP_SHIR  = 16'h0800,
    TAP_EX1IR = 16'h1000,
    TAP_PAUIR = 16'h2000,
    TAP_EX2IR = 16'h4000,
    TAP_UPIR  = 16'h8000
  } tap_state_t;

  // debug bus sequencer states
  typedef enum logic [3:0] {
    BUS_IDLE  = 4'b0001,
    BUS_READ  = 4'b0010,
    BUS_WRITE = 4'b0100,
    BUS_WAIT  = 4'b1000
  } bus_state_t;

  // tap position decode shared by the data path and bus sequencer
  typedef struct packed {
    logic in_tlr;
    logic cap_dr;
    logic sh_dr;
    logic up_dr;
    logic sh_ir;
  } tap_stat_t;

  // bus sequencer strobes toward the data registers
  typedef struct packed {
    logic do_read;
    logic do_write;
  } bus_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/jdtm_tap.sv @@
// tap controller state machine and instruction register
`timescale 1ns / 1ps
`default_nettype none

module jdtm_tap (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic                          tck_edge,
  input  wire logic                          tms,
  input  wire logic                          tdi,
  input  wire logic                          test_reset_n,
  input  wire logic                          status_hard_reset,
  output jdtm_pkg::tap_stat_t                stat,
  output logic [jdtm_pkg::IR_BITS-1:0]       ir
);

  jdtm_pkg::tap_state_t tap_r, tap_nxt, tap_adv;
  logic [jdtm_pkg::IR_BITS-1:0] ir_r, ir_nxt;

  // position decode
  assign stat.in_tlr = (tap_r == jdtm_pkg::TAP_TLR);
  assign stat.cap_dr = (tap_r == jdtm_pkg::TAP_CAPDR);
  assign stat.sh_dr  = (tap_r == jdtm_pkg::TAP_SHDR);
  assign stat.up_dr  = (tap_r == jdtm_pkg::TAP_UPDR);
  assign stat.sh_ir  = (tap_r == jdtm_pkg::TAP_SHIR);
  assign ir = ir_r;

  // standard tap transitions plus forced reset from the status register
  always_comb begin
    unique case (tap_r)
      jdtm_pkg::TAP_TLR:   tap_adv = tms ? jdtm_pkg::TAP_TLR   : jdtm_pkg::TAP_RTI;
      jdtm_pkg::TAP_RTI:   tap_adv = tms ? jdtm_pkg::TAP_SELDR : jdtm_pkg::TAP_RTI;
      jdtm_pkg::TAP_SELDR: tap_adv = tms ? jdtm_pkg::TAP_SELIR : jdtm_pkg::TAP_CAPDR;
      jdtm_pkg::TAP_CAPDR: tap_adv = tms ? jdtm_pkg::TAP_EX1DR : jdtm_pkg::TAP_SHDR;
      jdtm_pkg::TAP_SHDR:  tap_adv = tms ? jdtm_pkg::TAP_EX1DR : jdtm_pkg::TAP_SHDR;
      jdtm_pkg::TAP_EX1DR: tap_adv = tms ? jdtm_pkg::TAP_UPDR  : jdtm_pkg::TAP_PAUDR;
      jdtm_pkg::TAP_PAUDR: tap_adv = tms ? jdtm_pkg::TAP_EX2DR : jdtm_pkg::TAP_PAUDR;
      jdtm_pkg::TAP_EX2DR: tap_adv = tms ? jdtm_pkg::TAP_UPDR  : jdtm_pkg::TAP_SHDR;
      jdtm_pkg::TAP_UPDR: begin
        if (ir_r == jdtm_pkg::INS_DTMCS && status_hard_reset) begin
          tap_adv = jdtm_pkg::TAP_TLR;
        end else begin
          tap_adv = tms ? jdtm_pkg::TAP_SELDR : jdtm_pkg::TAP_RTI;
        end
      end
      jdtm_pkg::TAP_SELIR: tap_adv = tms ? jdtm_pkg::TAP_TLR   : jdtm_pkg::TAP_CAPIR;
      jdtm_pkg::TAP_CAPIR: tap_adv = tms ? jdtm_pkg::TAP_EX1IR : jdtm_pkg::TAP_SHIR;
      jdtm_pkg::TAP_SHIR:  tap_adv = tms ? jdtm_pkg::TAP_EX1IR : jdtm_pkg::TAP_SHIR;
      jdtm_pkg::TAP_EX1IR: tap_adv = tms ? jdtm_pkg::TAP_UPIR  : jdtm_pkg::TAP_PAUIR;
      jdtm_pkg::TAP_PAUIR: tap_adv = tms ? jdtm_pkg::TAP_EX2IR : jdtm_pkg::TAP_PAUIR;
      jdtm_pkg::TAP_EX2IR: tap_adv = tms ? jdtm_pkg::TAP_UPIR  : jdtm_pkg::TAP_SHIR;
      default:             tap_adv = tms ? jdtm_pkg::TAP_SELDR : jdtm_pkg::TAP_RTI;
    endcase
  end

  // advance on a test clock edge, test reset wins
  always_comb begin
    tap_nxt = tap_r;
    if (step) begin
      if (!test_reset_n) begin
        tap_nxt = jdtm_pkg::TAP_TLR;
      end else if (tck_edge) begin
        tap_nxt = tap_adv;
      end
    end
  end

  // instruction register shifts in shift-ir, loads idcode in reset
  always_comb begin
    ir_nxt = ir_r;
    if (step && tck_edge) begin
      if (stat.in_tlr) begin
        ir_nxt = jdtm_pkg::INS_IDCODE;
      end else if (stat.sh_ir) begin
        ir_nxt = {tdi, ir_r[jdtm_pkg::IR_BITS-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= jdtm_pkg::TAP_TLR;
      ir_r  <= jdtm_pkg::INS_IDCODE;
    end else begin
      tap_r <= tap_nxt;
      ir_r  <= ir_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jdtm_dr.sv @@
// data registers (bypass, idcode, status, bus access) and tdo select
`timescale 1ns / 1ps
`default_nettype none

module jdtm_dr #(
  parameter int ADDRESS_BITS = jdtm_pkg::ADDRESS_BITS_DEF,
  localparam int BB = ADDRESS_BITS + jdtm_pkg::BUS_FIXED_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire logic                            tck_edge,
  input  wire logic                            tdi,
  input  wire logic [jdtm_pkg::DATA_BITS-1:0]  read_data,
  input  wire jdtm_pkg::tap_stat_t             stat,
  input  wire logic [jdtm_pkg::IR_BITS-1:0]    ir,
  input  wire jdtm_pkg::bus_ctl_t              bus_ctl,
  input  wire logic [31:0]                     idcode_value,
  input  wire logic [2:0]                      idle_hint,
  output logic                                 tdo,
  output logic                                 status_hard_reset,
  output logic [BB-1:0]                        bus_shift
);

  logic          bypass_r, bypass_nxt;
  logic [31:0]   ident_r, ident_nxt;
  logic [31:0]   status_r, status_nxt;
  logic [BB-1:0] bus_r, bus_nxt;
  logic [31:0]   status_word;
  logic          edge_go;
  logic          is_byp, is_id, is_dtm, is_dmi;

  assign edge_go = step && tck_edge;
  assign is_byp  = (ir == jdtm_pkg::INS_BYPASS);
  assign is_id   = (ir == jdtm_pkg::INS_IDCODE);
  assign is_dtm  = (ir == jdtm_pkg::INS_DTMCS);
  assign is_dmi  = (ir == jdtm_pkg::INS_DMI);

  assign status_word = (32'(idle_hint) << 12) | (32'(ADDRESS_BITS) << 4) | 32'd1;
  assign status_hard_reset = status_r[jdtm_pkg::HARD_RESET_BIT];
  assign bus_shift = bus_r;

  // tdo from the selected register while shifting
  always_comb begin
    tdo = 1'b0;
    if (stat.sh_ir) begin
      tdo = ir[0];
    end else if (stat.sh_dr) begin
      priority if (is_byp) tdo = bypass_r;
      else if (is_id)      tdo = ident_r[0];
      else if (is_dtm)     tdo = status_r[0];
      else if (is_dmi)     tdo = bus_r[0];
      else                 tdo = 1'b0;
    end
  end

  // next values of the data registers
  always_comb begin
    bypass_nxt = bypass_r;
    ident_nxt  = ident_r;
    status_nxt = status_r;
    bus_nxt    = bus_r;
    if (edge_go && stat.in_tlr) begin
      bypass_nxt = 1'b0;
      ident_nxt  = '0;
      status_nxt = '0;
      bus_nxt    = '0;
    end else if (step) begin
      if (edge_go && stat.sh_dr && is_byp) begin
        bypass_nxt = tdi;
      end
      if (edge_go && is_id) begin
        if (stat.cap_dr) begin
          ident_nxt = idcode_value;
        end else if (stat.sh_dr) begin
          ident_nxt = {tdi, ident_r[31:1]};
        end
      end
      if (edge_go && is_dtm) begin
        if (stat.cap_dr) begin
          status_nxt = status_word;
        end else if (stat.sh_dr) begin
          status_nxt = {tdi, status_r[31:1]};
        end
      end
      // capture on the bus register holds it and masks the bus update
      priority if (edge_go && is_dmi && stat.cap_dr) begin
        bus_nxt = bus_r;
      end else if (edge_go && is_dmi && stat.sh_dr) begin
        bus_nxt = {tdi, bus_r[BB-1:1]};
      end else if (bus_ctl.do_read) begin
        bus_nxt = {{ADDRESS_BITS{1'b0}}, read_data, 2'b00};
      end else if (bus_ctl.do_write) begin
        bus_nxt = {bus_r[BB-1:2], 2'b00};
      end else begin
        bus_nxt = bus_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
      ident_r  <= '0;
      status_r <= '0;
      bus_r    <= '0;
    end else begin
      bypass_r <= bypass_nxt;
      ident_r  <= ident_nxt;
      status_r <= status_nxt;
      bus_r    <= bus_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jdtm_dmi.sv @@
// debug bus sequencer: read or write strobe after update-dr
`timescale 1ns / 1ps
`default_nettype none

module jdtm_dmi #(
  parameter int ADDRESS_BITS = jdtm_pkg::ADDRESS_BITS_DEF,
  localparam int BB = ADDRESS_BITS + jdtm_pkg::BUS_FIXED_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire logic                            test_reset_n,
  input  wire jdtm_pkg::tap_stat_t             stat,
  input  wire logic [jdtm_pkg::IR_BITS-1:0]    ir,
  input  wire logic [BB-1:0]                   bus_shift,
  output jdtm_pkg::bus_ctl_t                   bus_ctl,
  output logic [ADDRESS_BITS-1:0]              address,
  output logic [jdtm_pkg::DATA_BITS-1:0]       write_data
);

  jdtm_pkg::bus_state_t phase_r, phase_nxt, phase_adv;
  logic [1:0] op;

  assign op = bus_shift[1:0];
  assign bus_ctl.do_read  = (phase_r == jdtm_pkg::BUS_READ);
  assign bus_ctl.do_write = (phase_r == jdtm_pkg::BUS_WRITE);

  // bus fields are shown only during a strobe
  assign address = (bus_ctl.do_read || bus_ctl.do_write)
                   ? bus_shift[BB-1:jdtm_pkg::BUS_FIXED_BITS] : '0;
  assign write_data = bus_ctl.do_write ? bus_shift[jdtm_pkg::BUS_FIXED_BITS-1:2] : '0;

  // sequencer transitions
  always_comb begin
    phase_adv = phase_r;
    unique case (phase_r)
      jdtm_pkg::BUS_IDLE: begin
        if (ir == jdtm_pkg::INS_DMI && stat.up_dr) begin
          if (op == jdtm_pkg::OP_READ) begin
            phase_adv = jdtm_pkg::BUS_READ;
          end else if (op == jdtm_pkg::OP_WRITE) begin
            phase_adv = jdtm_pkg::BUS_WRITE;
          end
        end
      end
      jdtm_pkg::BUS_READ:  phase_adv = jdtm_pkg::BUS_WAIT;
      jdtm_pkg::BUS_WRITE: phase_adv = jdtm_pkg::BUS_WAIT;
      jdtm_pkg::BUS_WAIT: begin
        if (!stat.up_dr) begin
          phase_adv = jdtm_pkg::BUS_IDLE;
        end
      end
      default: phase_adv = jdtm_pkg::BUS_IDLE;
    endcase
  end

  // test reset returns to idle
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      phase_nxt = test_reset_n ? phase_adv : jdtm_pkg::BUS_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jdtm_pkg::BUS_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jtag_debug_transport_module.sv @@
// top level of the jtag debug transport module with result register
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------------
//  in_      | input     | tck_edge, tms, tdi, test_reset_n, dmi_read_data
//  out_     | output    | tdo, dmi_address, dmi_write_data, read/write strobes
//  cfg_     | input     | write enable, register index, write data
//
// One beat in, one beat out: the tap, data registers and bus sequencer update
// from the accepted beat, and the result lands in the output register on the
// same edge. A stalled output holds in that register and blocks input only
// while it is full and not taken.
// Synchronous active-low reset puts the tap in test-logic-reset, the bus
// sequencer in idle and clears the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module jtag_debug_transport_module #(
  parameter int ADDRESS_BITS = jdtm_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_tck_edge,
  input  wire logic                                 in_tms,
  input  wire logic                                 in_tdi,
  input  wire logic                                 in_test_reset_n,
  input  wire logic [jdtm_pkg::DATA_BITS-1:0]       in_dmi_read_data,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_tdo,
  output logic [ADDRESS_BITS-1:0]                   out_dmi_address,
  output logic [jdtm_pkg::DATA_BITS-1:0]            out_dmi_write_data,
  output logic                                      out_dmi_read_strobe,
  output logic                                      out_dmi_write_strobe,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [jdtm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [jdtm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int BB = ADDRESS_BITS + jdtm_pkg::BUS_FIXED_BITS;

  logic [31:0] idcode_r;
  logic [2:0]  idle_r;

  logic step;
  jdtm_pkg::tap_stat_t             stat;
  jdtm_pkg::bus_ctl_t              bus_ctl;
  logic [jdtm_pkg::IR_BITS-1:0]    ir;
  logic                            hard_reset;
  logic                            tdo;
  logic [BB-1:0]                   bus_shift;
  logic [ADDRESS_BITS-1:0]         address;
  logic [jdtm_pkg::DATA_BITS-1:0]  write_data;

  logic                            out_valid_r, out_valid_nxt;
  logic                            tdo_r;
  logic [ADDRESS_BITS-1:0]         addr_r;
  logic [jdtm_pkg::DATA_BITS-1:0]  wdata_r;
  logic                            rd_r, wr_r;

  // accept while the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign step = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idcode_r <= jdtm_pkg::IDCODE_RESET;
      idle_r   <= jdtm_pkg::IDLE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == jdtm_pkg::CFG_IDCODE) begin
        idcode_r <= cfg_wdata;
      end else if (cfg_index == jdtm_pkg::CFG_IDLE) begin
        idle_r <= cfg_wdata[2:0];
      end
    end
  end

  jdtm_tap u_tap (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .tck_edge          (in_tck_edge),
    .tms               (in_tms),
    .tdi               (in_tdi),
    .test_reset_n      (in_test_reset_n),
    .status_hard_reset (hard_reset),
    .stat              (stat),
    .ir                (ir)
  );

  jdtm_dr #(.ADDRESS_BITS(ADDRESS_BITS)) u_dr (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .tck_edge          (in_tck_edge),
    .tdi               (in_tdi),
    .read_data         (in_dmi_read_data),
    .stat              (stat),
    .ir                (ir),
    .bus_ctl           (bus_ctl),
    .idcode_value      (idcode_r),
    .idle_hint         (idle_r),
    .tdo               (tdo),
    .status_hard_reset (hard_reset),
    .bus_shift         (bus_shift)
  );

  jdtm_dmi #(.ADDRESS_BITS(ADDRESS_BITS)) u_dmi (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .test_reset_n (in_test_reset_n),
    .stat         (stat),
    .ir           (ir),
    .bus_shift    (bus_shift),
    .bus_ctl      (bus_ctl),
    .address      (address),
    .write_data   (write_data)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tdo_r   <= tdo;
      addr_r  <= address;
      wdata_r <= write_data;
      rd_r    <= bus_ctl.do_read;
      wr_r    <= bus_ctl.do_write;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tdo              = tdo_r;
  assign out_dmi_address      = addr_r;
  assign out_dmi_write_data   = wdata_r;
  assign out_dmi_read_strobe  = rd_r;
  assign out_dmi_write_strobe = wr_r;

`ifndef ASSERT_OFF
  // a bus beat is a read or a write, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rd_r && wr_r))
    else $error("read and write strobe in one beat");

  // write data appears only with the write strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !wr_r) |-> (wdata_r == '0))
    else $error("write data outside write strobe");

  // address appears only with a strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !rd_r && !wr_r) |-> (addr_r == '0))
    else $error("address outside bus strobe");

  // a bus strobe ends once the beat that carries it is accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && (bus_ctl.do_read || bus_ctl.do_write)) |=>
      !(bus_ctl.do_read || bus_ctl.do_write))
    else $error("bus strobe lasted more than one beat");
`endif

endmodule

`default_nettype wire
